// ----- design/rob_pkg.sv -----
// Shared types, constants and helper functions for the block reorder buffer.
// No dependencies; every design file refers to this package by scoped names.
package rob_pkg;

  localparam int WINDOW        = 16;
  localparam int PAYLOAD_BYTES = 8;
  localparam int MAX_OUT       = 16;
  localparam int Q_DEPTH       = 2;

  localparam int ID_W   = 16;
  localparam int PAY_W  = 64;
  localparam int LEN_W  = 4;
  localparam int HELD_W = 5;
  localparam int STAT_W = 2;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int HOLD_W = $clog2(WINDOW + 1);
  localparam int CNT_W  = $clog2(MAX_OUT + 1);
  localparam int Q_AW   = $clog2(Q_DEPTH);
  localparam int Q_CW   = $clog2(Q_DEPTH + 1);
  localparam int HELD_MAX = (1 << HELD_W) - 1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_WINDOW = 2'd1,
    STAT_DUP    = 2'd2
  } status_t;

  typedef struct packed {
    logic              store;
    logic [SLOT_W-1:0] slot;
    logic [PAY_W-1:0]  payload;
    logic [LEN_W-1:0]  length;
    status_t           status;
  } job_t;

  typedef struct packed {
    logic              idle;
    logic [ID_W-1:0]   expected_id;
    logic [SLOT_W-1:0] head;
    logic [WINDOW-1:0] valid;
  } view_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    if (int'(len) > PAYLOAD_BYTES) begin
      return LEN_W'(PAYLOAD_BYTES);
    end
    return len;
  endfunction

  function automatic logic [PAY_W-1:0] mask_payload(input logic [PAY_W-1:0] pay,
                                                    input logic [LEN_W-1:0] len);
    logic [PAY_W-1:0] res;
    res = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (i < int'(len)) begin
        res[i*8 +: 8] = pay[i*8 +: 8];
      end
    end
    return res;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] head,
                                                 input logic [SLOT_W-1:0] gap);
    logic [SLOT_W:0] sum;
    sum = {1'b0, head} + {1'b0, gap};
    if (int'(sum) >= WINDOW) begin
      sum = sum - (SLOT_W+1)'(WINDOW);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (int'(s) == WINDOW - 1) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  function automatic logic [HELD_W-1:0] held_sat(input logic [HOLD_W-1:0] h);
    if (int'(h) > HELD_MAX) begin
      return '1;
    end
    return HELD_W'(h);
  endfunction

endpackage

// ----- design/rob_front.sv -----
// Front end of the reorder buffer: accepts a block, checks its number against
// the window and the slot marks, and pushes a classified job. Uses rob_pkg.
module rob_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rob_pkg::ID_W-1:0]    in_block_id,
  input  logic [rob_pkg::PAY_W-1:0]   in_payload,
  input  logic [rob_pkg::LEN_W-1:0]   in_length,
  input  rob_pkg::view_t              view,
  input  logic                        q_empty,
  output logic                        push,
  output rob_pkg::job_t               push_job
);

  logic [rob_pkg::ID_W-1:0]   gap;
  logic                       in_window;
  logic [rob_pkg::SLOT_W-1:0] slot;
  logic [rob_pkg::LEN_W-1:0]  len_sat;

  assign in_stall = !(view.idle && q_empty);
  assign push     = in_valid && !in_stall;

  assign gap       = in_block_id - view.expected_id;
  assign in_window = gap < rob_pkg::ID_W'(rob_pkg::WINDOW);
  assign slot      = rob_pkg::slot_add(view.head, gap[rob_pkg::SLOT_W-1:0]);
  assign len_sat   = rob_pkg::sat_len(in_length);

  always_comb begin
    push_job.slot    = slot;
    push_job.payload = rob_pkg::mask_payload(in_payload, len_sat);
    push_job.length  = len_sat;
    push_job.store   = 1'b0;
    if (!in_window) begin
      push_job.status = rob_pkg::STAT_WINDOW;
    end else if (view.valid[slot]) begin
      push_job.status = rob_pkg::STAT_DUP;
    end else begin
      push_job.status = rob_pkg::STAT_OK;
      push_job.store  = 1'b1;
    end
  end

endmodule

// ----- design/rob_queue.sv -----
// Short job queue between the front end and the back end.
// Carries rob_pkg::job_t entries; depth set by rob_pkg::Q_DEPTH.
module rob_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rob_pkg::job_t push_job,
  input  logic          pop,
  output rob_pkg::job_t pop_job,
  output logic          empty
);

  rob_pkg::job_t              entry_r [rob_pkg::Q_DEPTH];
  logic [rob_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [rob_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [rob_pkg::Q_CW-1:0]   count_r;
  logic                       do_push;
  logic                       do_pop;

  function automatic logic [rob_pkg::Q_AW-1:0] ptr_inc(input logic [rob_pkg::Q_AW-1:0] p);
    if (int'(p) == rob_pkg::Q_DEPTH - 1) begin
      return '0;
    end
    return p + rob_pkg::Q_AW'(1);
  endfunction

  assign empty   = (count_r == '0);
  assign do_push = push && (int'(count_r) < rob_pkg::Q_DEPTH);
  assign do_pop  = pop && !empty;
  assign pop_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + rob_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - rob_pkg::Q_CW'(1);
      end
    end
  end

endmodule

// ----- design/rob_back.sv -----
// Back end of the reorder buffer: slot store, window state and in-order release.
// Pops jobs from rob_queue, drives the result register. Uses rob_pkg.
module rob_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rob_pkg::ID_W-1:0]     cfg_start_id,
  input  logic                         q_empty,
  input  rob_pkg::job_t                q_job,
  output logic                         pop,
  output rob_pkg::view_t               view,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_out_valid,
  output logic [rob_pkg::ID_W-1:0]     out_id,
  output logic [rob_pkg::PAY_W-1:0]    out_payload,
  output logic [rob_pkg::LEN_W-1:0]    out_length,
  output logic                         out_last,
  output logic [rob_pkg::HELD_W-1:0]   out_held_count,
  output logic [rob_pkg::STAT_W-1:0]   out_status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STORE,
    ST_LOOK,
    ST_EMIT
  } state_t;

  state_t                          state_r;
  rob_pkg::job_t                   job_r;
  logic [rob_pkg::WINDOW-1:0]      valid_r;
  logic [rob_pkg::ID_W-1:0]        expected_r;
  logic [rob_pkg::SLOT_W-1:0]      head_r;
  logic [rob_pkg::HOLD_W-1:0]      held_r;
  logic [rob_pkg::CNT_W-1:0]       cnt_r;
  logic [rob_pkg::ID_W-1:0]        id_r;

  logic [rob_pkg::PAY_W-1:0]       mem_pay [rob_pkg::WINDOW];
  logic [rob_pkg::LEN_W-1:0]       mem_len [rob_pkg::WINDOW];
  logic [rob_pkg::PAY_W-1:0]       rd_pay_r;
  logic [rob_pkg::LEN_W-1:0]       rd_len_r;

  logic                            out_valid_r;
  logic                            out_rel_r;
  logic [rob_pkg::ID_W-1:0]        out_id_r;
  logic [rob_pkg::PAY_W-1:0]       out_pay_r;
  logic [rob_pkg::LEN_W-1:0]       out_len_r;
  logic                            out_last_r;
  logic [rob_pkg::HELD_W-1:0]      out_held_r;
  rob_pkg::status_t                out_status_r;

  logic                            out_free;
  logic                            head_ready;
  logic                            last_c;
  logic                            advance;
  logic                            do_store;
  logic                            emit;

  assign out_free   = !out_valid_r || !out_stall;
  assign head_ready = valid_r[head_r];
  assign last_c     = !head_ready || (cnt_r == rob_pkg::CNT_W'(rob_pkg::MAX_OUT));
  assign pop        = (state_r == ST_IDLE) && !q_empty;
  assign do_store   = (state_r == ST_STORE) && job_r.store;
  assign emit       = out_free && (((state_r == ST_LOOK) && !head_ready) ||
                                   (state_r == ST_EMIT));

  always_comb begin
    unique case (state_r)
      ST_LOOK: advance = head_ready;
      ST_EMIT: advance = out_free && !last_c;
      default: advance = 1'b0;
    endcase
  end

  assign view.idle        = (state_r == ST_IDLE);
  assign view.expected_id = expected_r;
  assign view.head        = head_r;
  assign view.valid       = valid_r;

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem_pay[job_r.slot] <= job_r.payload;
      mem_len[job_r.slot] <= job_r.length;
    end
    if (advance) begin
      rd_pay_r <= mem_pay[head_r];
      rd_len_r <= mem_len[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      expected_r  <= '0;
      head_r      <= '0;
      held_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_job;
            state_r <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (job_r.store) begin
            valid_r[job_r.slot] <= 1'b1;
            held_r              <= held_r + rob_pkg::HOLD_W'(1);
          end
          cnt_r   <= '0;
          state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          if (head_ready) begin
            state_r <= ST_EMIT;
          end else if (out_free) begin
            out_rel_r    <= 1'b0;
            out_id_r     <= '0;
            out_pay_r    <= '0;
            out_len_r    <= '0;
            out_last_r   <= 1'b1;
            out_held_r   <= rob_pkg::held_sat(held_r);
            out_status_r <= job_r.status;
            state_r      <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_rel_r    <= 1'b1;
            out_id_r     <= id_r;
            out_pay_r    <= rd_pay_r;
            out_len_r    <= rd_len_r;
            out_last_r   <= last_c;
            out_held_r   <= rob_pkg::held_sat(held_r);
            out_status_r <= job_r.status;
            if (last_c) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cfg_we) begin
        valid_r    <= '0;
        held_r     <= '0;
        head_r     <= '0;
        expected_r <= cfg_start_id;
      end else if (advance) begin
        valid_r[head_r] <= 1'b0;
        held_r          <= held_r - rob_pkg::HOLD_W'(1);
        id_r            <= expected_r;
        expected_r      <= expected_r + rob_pkg::ID_W'(1);
        head_r          <= rob_pkg::slot_inc(head_r);
        cnt_r           <= cnt_r + rob_pkg::CNT_W'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_valid  = out_rel_r;
  assign out_id         = out_id_r;
  assign out_payload    = out_pay_r;
  assign out_length     = out_len_r;
  assign out_last       = out_last_r;
  assign out_held_count = out_held_r;
  assign out_status     = out_status_r;

endmodule

// ----- design/block_reorder_buffer.sv -----
// Top level of the block reorder buffer: front end, job queue and back end.
// Depends on rob_pkg, rob_front, rob_queue and rob_back.
//
// Input channel (in_valid / in_stall): one beat carries a block number, up to
// eight payload bytes and a byte length. Result channel (out_valid /
// out_stall): one beat per block released in order, or one empty beat when
// nothing is released; out_last marks the final beat caused by an input.
// Every beat reports the held block count and the drop status of its input.
// cfg_we loads cfg_start_id as the expected number and empties the window.
//
// An input beat is taken only when the back end and the queue are empty, so
// items are handled one at a time. An input passes through the job queue and
// the back end states ST_STORE and ST_LOOK; an empty result is registered from
// ST_LOOK, released blocks from ST_EMIT. While the result channel is not
// stalled, further releases follow one per cycle, as the release loop of the
// back end reads one slot per cycle.
// Reset clears all slot marks, the held count and the expected number (zero).
// A stalled result beat holds, and the item waits for it.
module block_reorder_buffer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rob_pkg::ID_W-1:0]     cfg_start_id,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rob_pkg::ID_W-1:0]     in_block_id,
  input  logic [rob_pkg::PAY_W-1:0]    in_payload,
  input  logic [rob_pkg::LEN_W-1:0]    in_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_out_valid,
  output logic [rob_pkg::ID_W-1:0]     out_id,
  output logic [rob_pkg::PAY_W-1:0]    out_payload,
  output logic [rob_pkg::LEN_W-1:0]    out_length,
  output logic                         out_last,
  output logic [rob_pkg::HELD_W-1:0]   out_held_count,
  output logic [rob_pkg::STAT_W-1:0]   out_status
);

  rob_pkg::view_t view;
  rob_pkg::job_t  push_job;
  rob_pkg::job_t  pop_job;
  logic           push;
  logic           pop;
  logic           q_empty;

  rob_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_block_id (in_block_id),
    .in_payload  (in_payload),
    .in_length   (in_length),
    .view        (view),
    .q_empty     (q_empty),
    .push        (push),
    .push_job    (push_job)
  );

  rob_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  rob_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_start_id   (cfg_start_id),
    .q_empty        (q_empty),
    .q_job          (pop_job),
    .pop            (pop),
    .view           (view),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_valid  (out_out_valid),
    .out_id         (out_id),
    .out_payload    (out_payload),
    .out_length     (out_length),
    .out_last       (out_last),
    .out_held_count (out_held_count),
    .out_status     (out_status)
  );

endmodule

// ----- tb/sv/tb_block_reorder_buffer.sv -----
// Self-checking testbench for block_reorder_buffer: in-order release of blocks
// tagged with sequence numbers, checked beat by beat against a local window model.
// Depends on rob_pkg and the block_reorder_buffer RTL.
module tb_block_reorder_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import rob_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_BEAT = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BLOCKS = 80;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] pay;
    logic [LEN_W-1:0] len;
  } blk_t;

  typedef struct packed {
    logic              rel;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  pay;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic [HELD_W-1:0] held;
    status_t           st;
  } rel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [ID_W-1:0]   cfg_start_id = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ID_W-1:0]   in_block_id = '0;
  logic [PAY_W-1:0]  in_payload = '0;
  logic [LEN_W-1:0]  in_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_out_valid;
  logic [ID_W-1:0]   out_id;
  logic [PAY_W-1:0]  out_payload;
  logic [LEN_W-1:0]  out_length;
  logic              out_last;
  logic [HELD_W-1:0] out_held_count;
  logic [STAT_W-1:0] out_status;

  blk_t pending_blocks[$];
  rel_t expected_releases[$];

  int   send_idle = 0;
  int   recv_idle = 0;
  int   blocks_queued = 0;
  int   blocks_taken = 0;
  int   out_beats = 0;
  int   errors = 0;
  int   quiet = 0;
  int   phase_count = 0;
  logic in_took = 1'b0;
  logic [ID_W-1:0] gen_next = '0;

  // window model
  logic [PAY_W-1:0] win_pay [WINDOW];
  logic [LEN_W-1:0] win_len [WINDOW];
  logic [WINDOW-1:0] win_full;
  logic [ID_W-1:0]  next_id;
  logic [ID_W-1:0]  start_reg;
  int               win_head;
  int               win_held;

  block_reorder_buffer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_start_id   (cfg_start_id),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_block_id    (in_block_id),
    .in_payload     (in_payload),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_valid  (out_out_valid),
    .out_id         (out_id),
    .out_payload    (out_payload),
    .out_length     (out_length),
    .out_last       (out_last),
    .out_held_count (out_held_count),
    .out_status     (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [PAY_W-1:0] keep_bytes(logic [PAY_W-1:0] p, int n);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (i >= n) begin
        p[i*8 +: 8] = 8'h00;
      end
    end
    return p;
  endfunction

  task automatic clear_window();
    win_full = '0;
    win_held = 0;
    win_head = 0;
    next_id  = start_reg;
  endtask

  task automatic predict_release(input blk_t b);
    logic [ID_W-1:0] gap;
    int              n;
    int              s;
    int              len;
    status_t         st;
    rel_t            r;
    len  = (int'(b.len) > PAYLOAD_BYTES) ? PAYLOAD_BYTES : int'(b.len);
    gap  = b.id - next_id;
    if (int'(gap) >= WINDOW) begin
      st = STAT_WINDOW;
    end else begin
      s = (win_head + int'(gap)) % WINDOW;
      if (win_full[s]) begin
        st = STAT_DUP;
      end else begin
        st          = STAT_OK;
        win_full[s] = 1'b1;
        win_pay[s]  = keep_bytes(b.pay, len);
        win_len[s]  = LEN_W'(len);
        win_held++;
      end
    end
    n = 0;
    while (n < MAX_OUT && win_full[win_head]) begin
      win_full[win_head] = 1'b0;
      win_held--;
      r.rel  = 1'b1;
      r.id   = next_id;
      r.pay  = win_pay[win_head];
      r.len  = win_len[win_head];
      r.held = (win_held > HELD_MAX) ? HELD_W'(HELD_MAX) : HELD_W'(win_held);
      r.st   = st;
      next_id  = next_id + ID_W'(1);
      win_head = (win_head + 1) % WINDOW;
      n++;
      r.last = (n == MAX_OUT) || !win_full[win_head];
      expected_releases.push_back(r);
    end
    if (n == 0) begin
      r      = '0;
      r.last = 1'b1;
      r.held = (win_held > HELD_MAX) ? HELD_W'(HELD_MAX) : HELD_W'(win_held);
      r.st   = st;
      expected_releases.push_back(r);
    end
  endtask

  // sample both channels, run the model and check results
  always @(posedge clk) begin : monitor
    rel_t want;
    rel_t got;
    blk_t b;
    if (!rst_n) begin
      start_reg = '0;
      clear_window();
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (cfg_we) begin
        start_reg = cfg_start_id;
        clear_window();
      end
      if (in_valid && !in_stall) begin
        b.id  = in_block_id;
        b.pay = in_payload;
        b.len = in_length;
        predict_release(b);
        blocks_taken <= blocks_taken + 1;
      end
      if (out_valid && !out_stall) begin
        out_beats <= out_beats + 1;
        got.rel  = out_out_valid;
        got.id   = out_id;
        got.pay  = out_payload;
        got.len  = out_length;
        got.last = out_last;
        got.held = out_held_count;
        got.st   = status_t'(out_status);
        if (expected_releases.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("unexpected beat: rel=%0d id=%h pay=%h len=%0d last=%0d held=%0d st=%0d",
                     got.rel, got.id, got.pay, got.len, got.last, got.held, got.st);
          end
        end else begin
          want = expected_releases.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch: want rel=%0d id=%h pay=%h len=%0d last=%0d held=%0d st=%0d",
                       want.rel, want.id, want.pay, want.len, want.last, want.held, want.st);
              $display("          got  rel=%0d id=%h pay=%h len=%0d last=%0d held=%0d st=%0d",
                       got.rel, got.id, got.pay, got.len, got.last, got.held, got.st);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_block_reorder_buffer: FAIL");
      $finish;
    end else if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  always @(negedge clk) begin : driver
    blk_t b;
    if (!(in_valid && !in_took)) begin
      if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle) begin
        b = pending_blocks.pop_front();
        in_block_id <= b.id;
        in_payload  <= b.pay;
        in_length   <= b.len;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    int hold_left;
    bit hold_done;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && out_beats >= HOLD_AT_BEAT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic set_mode(input int s_idle, input int r_idle);
    send_idle <= s_idle;
    recv_idle <= r_idle;
  endtask

  task automatic write_start(input logic [ID_W-1:0] v);
    @(negedge clk);
    cfg_start_id <= v;
    cfg_we       <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    gen_next = v;
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (blocks_taken != blocks_queued || expected_releases.size() != 0);
  endtask

  task automatic queue_block(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                             input logic [PAY_W-1:0] pay);
    blk_t b;
    b.id  = id;
    b.pay = pay;
    b.len = len;
    pending_blocks.push_back(b);
    blocks_queued++;
    phase_count++;
  endtask

  function automatic logic [PAY_W-1:0] rand_pay();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_noise();
    logic [ID_W-1:0] id;
    case ($urandom_range(3))
      0:       id = gen_next + ID_W'($urandom_range(0, WINDOW - 1));
      1:       id = gen_next - ID_W'($urandom_range(1, 300));
      2:       id = gen_next + ID_W'(WINDOW) + ID_W'($urandom_range(0, 4000));
      default: id = ID_W'($urandom);
    endcase
    queue_block(id, LEN_W'($urandom_range(0, 15)), rand_pay());
  endtask

  // consecutive run of numbers in shuffled order, sometimes with one held back
  task automatic queue_burst();
    logic [ID_W-1:0] ids [MAX_OUT];
    logic [ID_W-1:0] t;
    int              k;
    int              j;
    int              miss;
    k = ($urandom_range(7) == 0) ? WINDOW : $urandom_range(1, 8);
    for (int i = 0; i < k; i++) begin
      ids[i] = gen_next + ID_W'(i);
    end
    for (int i = k - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      t      = ids[i];
      ids[i] = ids[j];
      ids[j] = t;
    end
    miss = -1;
    if (k > 1 && $urandom_range(9) == 0) begin
      miss = $urandom_range(0, k - 1);
    end
    for (int i = 0; i < k; i++) begin
      if (i != miss) begin
        queue_block(ids[i], LEN_W'($urandom_range(0, 15)), rand_pay());
      end
      if ($urandom_range(9) == 0) begin
        queue_noise();
      end
    end
    if (miss >= 0) begin
      repeat ($urandom_range(1, 3)) queue_noise();
      queue_block(ids[miss], LEN_W'($urandom_range(0, 15)), rand_pay());
    end
    gen_next = gen_next + ID_W'(k);
  endtask

  task automatic random_phase();
    phase_count = 0;
    while (phase_count < PHASE_BLOCKS) begin
      queue_burst();
    end
  endtask

  initial begin : stimulus
    logic [ID_W-1:0] base;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    set_mode(27, 75);

    base = 16'hFFFA;
    write_start(base);
    queue_block(base, 4'd8, '1);
    queue_block(base + 16'd2, 4'd0, rand_pay());
    queue_block(base + 16'd2, 4'd5, rand_pay());
    queue_block(base + 16'd1, 4'd15, '1);
    queue_block(base + 16'd2, 4'd3, rand_pay());
    queue_block(base + 16'd3 + ID_W'(WINDOW), 4'd4, rand_pay());
    queue_block(base + 16'd3 + ID_W'(WINDOW - 1), 4'd1, '0);
    for (int d = 1; d < WINDOW - 1; d++) begin
      queue_block(base + 16'd3 + ID_W'(d), LEN_W'($urandom_range(0, 15)), rand_pay());
    end
    queue_block(base + 16'd3, 4'd8, rand_pay());
    drain();

    write_start(16'hFFFF);
    random_phase();
    drain();

    set_mode(75, 27);
    write_start(16'h0000);
    random_phase();
    drain();

    set_mode(0, 0);
    write_start(ID_W'($urandom));
    random_phase();
    drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_releases.size() == 0) begin
      $display("tb_block_reorder_buffer: PASS");
    end else begin
      $display("tb_block_reorder_buffer: FAIL");
    end
    $finish;
  end

endmodule
